[rtl/core/oisl_pkg.sv]
package oisl_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] SEC_CODE   = 16'hCADE;
    localparam logic [15:0] SEC_DATA   = 16'hDADA;
    localparam logic [15:0] SEC_SYMBOL = 16'hC3B7;
    localparam logic [15:0] SEC_FILE   = 16'hF17E;
    localparam logic [15:0] SEC_LINE   = 16'h715E;

    typedef enum logic [10:0] {
        PH_CODE_HI = 11'b000_0000_0001,
        PH_CODE_LO = 11'b000_0000_0010,
        PH_ADDR_HI = 11'b000_0000_0100,
        PH_ADDR_LO = 11'b000_0000_1000,
        PH_N_HI    = 11'b000_0001_0000,
        PH_N_LO    = 11'b000_0010_0000,
        PH_WORD_HI = 11'b000_0100_0000,
        PH_WORD_LO = 11'b000_1000_0000,
        PH_SKIP    = 11'b001_0000_0000,
        PH_LINE_HI = 11'b010_0000_0000,
        PH_LINE_LO = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_TRUNC = 2'd2
    } t_kind;

    // one queue entry: optional memory write, optional end-of-image status
    typedef struct packed {
        logic        wr;
        logic        fin;
        t_kind       fin_kind;
        logic [15:0] addr;
        logic [15:0] word;
        logic [31:0] total;
    } t_evt;

endpackage

[rtl/core/oisl_front.sv]
module oisl_front
    import oisl_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_qfull,
    output logic       o_ready,
    output logic       o_push,
    output t_evt       o_evt
);

    localparam logic [15:0] AMASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_kind, n_kind;
    logic [15:0] r_base, n_base;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_ofs, n_ofs;
    logic [31:0] r_total, n_total;

    logic        accept;
    logic        wr;
    logic [15:0] hw;
    logic [15:0] rem_dec;
    logic [32:0] tsum;
    logic        is_cd;
    t_phase      ph_after;

    assign accept  = i_valid && !i_qfull;
    assign o_ready = !i_qfull;
    assign hw      = {r_held, i_byte};
    assign rem_dec = r_rem - 16'd1;
    assign tsum    = {1'b0, r_total} + {17'd0, hw};
    assign is_cd   = (r_kind == SEC_CODE) || (r_kind == SEC_DATA);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_kind  = r_kind;
        n_base  = r_base;
        n_rem   = r_rem;
        n_ofs   = r_ofs;
        n_total = r_total;
        wr      = 1'b0;
        case (r_phase)
            PH_CODE_LO: begin
                n_kind = hw;
                if (hw == SEC_CODE || hw == SEC_DATA || hw == SEC_SYMBOL || hw == SEC_LINE) begin
                    n_phase = PH_ADDR_HI;
                end else if (hw == SEC_FILE) begin
                    n_phase = PH_N_HI;
                end else begin
                    n_phase = PH_CODE_HI;
                end
            end
            PH_ADDR_HI: begin
                n_held  = i_byte;
                n_phase = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
                n_base  = hw;
                n_phase = PH_N_HI;
            end
            PH_N_HI: begin
                n_held  = i_byte;
                n_phase = PH_N_LO;
            end
            PH_N_LO: begin
                n_rem = hw;
                n_ofs = 16'd0;
                if (is_cd) begin
                    n_total = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                    n_phase = (hw == 16'd0) ? PH_CODE_HI : PH_WORD_HI;
                end else if (r_kind == SEC_LINE) begin
                    n_phase = PH_LINE_HI;
                end else begin
                    n_phase = (hw == 16'd0) ? PH_CODE_HI : PH_SKIP;
                end
            end
            PH_WORD_HI: begin
                n_held  = i_byte;
                n_phase = PH_WORD_LO;
            end
            PH_WORD_LO: begin
                wr      = 1'b1;
                n_ofs   = r_ofs + 16'd1;
                n_rem   = rem_dec;
                n_phase = (rem_dec == 16'd0) ? PH_CODE_HI : PH_WORD_HI;
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == 16'd0) begin
                    n_phase = PH_CODE_HI;
                end
            end
            PH_LINE_HI: begin
                n_held  = i_byte;
                n_phase = PH_LINE_LO;
            end
            PH_LINE_LO: begin
                n_phase = PH_CODE_HI;
            end
            default: begin
                n_held  = i_byte;
                n_phase = PH_CODE_LO;
            end
        endcase
        ph_after = n_phase;
        if (i_last) begin
            n_phase = PH_CODE_HI;
            n_held  = 8'd0;
            n_kind  = 16'd0;
            n_base  = 16'd0;
            n_rem   = 16'd0;
            n_ofs   = 16'd0;
        end
    end

    always_comb begin
        o_evt.wr       = wr;
        o_evt.fin      = i_last;
        o_evt.fin_kind = (ph_after == PH_CODE_HI || ph_after == PH_CODE_LO) ?
                         KIND_DONE : KIND_TRUNC;
        o_evt.addr     = (r_base + r_ofs) & AMASK;
        o_evt.word     = hw;
        o_evt.total    = n_total;
    end

    assign o_push = accept && (wr || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE_HI;
            r_held  <= 8'd0;
            r_kind  <= 16'd0;
            r_base  <= 16'd0;
            r_rem   <= 16'd0;
            r_ofs   <= 16'd0;
            r_total <= 32'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_kind  <= n_kind;
            r_base  <= n_base;
            r_rem   <= n_rem;
            r_ofs   <= n_ofs;
            r_total <= n_total;
        end
    end

endmodule

[rtl/core/oisl_queue.sv]
module oisl_queue
    import oisl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_evt o_head
);

    t_evt              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/core/oisl_back.sv]
module oisl_back
    import oisl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_evt        i_head,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [63:0] o_tdata,
    output logic [1:0]  o_tuser,
    output logic        o_tlast
);

    logic r_sub, n_sub;
    logic show_end;
    logic xfer;

    assign show_end = r_sub || !i_head.wr;
    assign xfer     = i_valid && i_tready;
    assign o_tvalid = i_valid;
    assign o_tlast  = show_end || !i_head.fin;
    assign o_pop    = xfer && o_tlast;
    assign o_tuser  = show_end ? i_head.fin_kind : KIND_WRITE;
    assign o_tdata  = show_end ? {i_head.total, 32'd0}
                               : {i_head.total, i_head.word, i_head.addr};

    always_comb begin
        n_sub = r_sub;
        if (xfer) begin
            n_sub = !show_end && i_head.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else begin
            r_sub <= n_sub;
        end
    end

endmodule

[rtl/core/object_image_section_loader_top.sv]
// Object image loader: takes one image byte per cycle on the slave stream and parses
// big-endian sections (code/data words become memory-write words; symbol, filename and
// line sections are skipped). A byte flagged with tlast closes the image with a
// complete or truncated status word. Input is taken every cycle while the 4-entry
// queue between parser and output stage has room; a byte that yields both a write and
// a status word sends the write first and the status word after it; sustained rate is
// one byte per cycle while the master side stays ready. Results are queued in registers.
module object_image_section_loader_top
    import oisl_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [15:0] write_address, [31:16] write_word,
                                          // [63:32] words_declared
    output logic [1:0]  o_m_axis_tuser,   // [1:0] result_kind
    output logic        o_m_axis_tlast
);

    logic qfull, qvalid, push, pop;
    t_evt evt, head;

    oisl_front #(
        .ADDR_BITS(ADDR_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_qfull (qfull),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_evt   (evt)
    );

    oisl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (evt),
        .i_pop   (pop),
        .o_full  (qfull),
        .o_valid (qvalid),
        .o_head  (head)
    );

    oisl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qvalid),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_WRITE |-> o_m_axis_tlast)
        else $error("status word without tlast");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_WRITE |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("status word carries address or data");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |=>
        !o_m_axis_tvalid || o_m_axis_tdata[63:32] >= $past(o_m_axis_tdata[63:32]))
        else $error("declared total went backwards");
`endif

endmodule
